[rtl/core/fifo_page_replacement_unit_assert.svh]
// Assertion macros for the page replacement unit checker
`ifndef FIFO_PAGE_REPLACEMENT_UNIT_ASSERT_SVH
`define FIFO_PAGE_REPLACEMENT_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset
`define FPR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("fpr assertion failed");

// Check that a condition implies another in the next cycle
`define FPR_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("fpr assertion failed");

`endif

[rtl/core/fpr_pkg.sv]
package fpr_pkg;

    localparam int CFG_W      = 7;
    localparam int SLOT_OUT_W = 6;
    localparam int TOTAL_W    = 32;
    localparam int OUT_W      = 72;
    localparam int OUT_PAD    = OUT_W - SLOT_OUT_W - 2 * TOTAL_W;

    localparam logic [CFG_W-1:0]   TABLE_SIZE_RST = 7'd64;
    localparam logic [TOTAL_W-1:0] COUNT_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic act;
        logic found;
    } t_tok;

endpackage

[rtl/core/fpr_cell.sv]
module fpr_cell #(
    parameter int PAGE_BITS = 20,
    parameter int SLOT_W    = 6,
    parameter int IDX       = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_active,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic                 i_wr_en,
    input  logic [SLOT_W-1:0]    i_wr_slot,
    input  fpr_pkg::t_tok        i_tok,
    input  logic [SLOT_W-1:0]    i_slot,
    output fpr_pkg::t_tok        o_tok,
    output logic [SLOT_W-1:0]    o_slot
);
    import fpr_pkg::*;

    localparam logic [SLOT_W-1:0] CELL_IDX = SLOT_W'(IDX);

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    t_tok                 r_tok;
    logic [SLOT_W-1:0]    r_slot;
    logic                 w_match;
    logic                 w_wr_hit;

    assign w_wr_hit = i_wr_en && (i_wr_slot == CELL_IDX);
    assign w_match  = i_tok.act && !i_tok.found && i_active && r_valid && (r_page == i_page);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            if (w_wr_hit) begin
                r_valid <= 1'b1;
                r_page  <= i_page;
            end
            r_tok.act   <= i_tok.act;
            r_tok.found <= i_tok.found | w_match;
            r_slot      <= w_match ? CELL_IDX : i_slot;
        end
    end

    assign o_tok  = r_tok;
    assign o_slot = r_slot;

endmodule

[rtl/core/fifo_page_replacement_unit.sv]
// An accepted page number is registered and a search token walks the row of
// ENTRIES cells one cell a cycle; the hit or fill is committed once the output
// register is free. No new page number is accepted until that commit.
// Reset: synchronous, active low; clears valid bits, insert pointer, hit and miss
// totals, and sets the table size to 64. No clearing pass is needed.
module fifo_page_replacement_unit #(
    parameter int ENTRIES   = 64,
    parameter int PAGE_BITS = 20
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [fpr_pkg::CFG_W-1:0]               i_cfg_wdata,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [PAGE_BITS-1:0] page_number
    input  logic [((PAGE_BITS + 7) / 8) * 8 - 1:0]  i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // [5:0] slot, [37:6] hit_total, [69:38] miss_total
    output logic [fpr_pkg::OUT_W-1:0]               o_m_axis_tdata,
    // [0] hit
    output logic                                    o_m_axis_tuser
);
    import fpr_pkg::*;

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_A  = $clog2(ENTRIES + 1);
    localparam int CNT_W  = (CNT_A > CFG_W) ? CNT_A : CFG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_table_size;
    logic                 r_launch;
    logic [PAGE_BITS-1:0] r_page;
    logic                 r_found;
    logic [SLOT_W-1:0]    r_slot;
    logic [SLOT_W-1:0]    r_ptr;
    logic [TOTAL_W-1:0]   r_hits;
    logic [TOTAL_W-1:0]   r_misses;
    logic                 r_out_vld;
    logic                 r_out_hit;
    logic [OUT_W-1:0]     r_out_data;

    logic [CNT_W-1:0]     w_size_ext;
    logic [CNT_W-1:0]     w_n;
    logic [ENTRIES-1:0]   w_active;
    t_tok                 w_tok  [0:ENTRIES];
    logic [SLOT_W-1:0]    w_slot [0:ENTRIES];
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_commit;
    logic                 w_wr_en;
    logic [SLOT_W-1:0]    w_ins;
    logic [CNT_W-1:0]     w_ins_inc;
    logic [SLOT_W-1:0]    n_ptr;
    logic [SLOT_W-1:0]    n_slot;
    logic [TOTAL_W-1:0]   n_hits;
    logic [TOTAL_W-1:0]   n_misses;

    assign w_size_ext = CNT_W'(r_table_size);

    always_comb begin
        if (w_size_ext == '0) begin
            w_n = CNT_W'(1);
        end else if (w_size_ext > CNT_W'(ENTRIES)) begin
            w_n = CNT_W'(ENTRIES);
        end else begin
            w_n = w_size_ext;
        end
    end

    assign w_tok[0]  = '{act: r_launch, found: 1'b0};
    assign w_slot[0] = '0;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        assign w_active[k] = (CNT_W'(k) < w_n);

        fpr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .SLOT_W    (SLOT_W),
            .IDX       (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_active  (w_active[k]),
            .i_page    (r_page),
            .i_wr_en   (w_wr_en),
            .i_wr_slot (w_ins),
            .i_tok     (w_tok[k]),
            .i_slot    (w_slot[k]),
            .o_tok     (w_tok[k+1]),
            .o_slot    (w_slot[k+1])
        );
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_vld || i_m_axis_tready;
    assign w_commit        = (r_state == S_COMMIT) && w_out_free;
    assign w_wr_en         = w_commit && !r_found;

    assign w_ins     = (CNT_W'(r_ptr) >= w_n) ? '0 : r_ptr;
    assign w_ins_inc = CNT_W'(w_ins) + CNT_W'(1);
    assign n_ptr     = (w_ins_inc >= w_n) ? '0 : w_ins_inc[SLOT_W-1:0];
    assign n_slot    = r_found ? r_slot : w_ins;
    assign n_hits    = (r_found && r_hits != COUNT_MAX) ? r_hits + 1'b1 : r_hits;
    assign n_misses  = (!r_found && r_misses != COUNT_MAX) ? r_misses + 1'b1 : r_misses;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_table_size <= TABLE_SIZE_RST;
            r_launch     <= 1'b0;
            r_ptr        <= '0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
            r_launch <= w_accept;
            if (w_commit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_page  <= i_s_axis_tdata[PAGE_BITS-1:0];
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (w_tok[ENTRIES].act) begin
                        r_found <= w_tok[ENTRIES].found;
                        r_slot  <= w_slot[ENTRIES];
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (w_out_free) begin
                        if (!r_found) begin
                            r_ptr <= n_ptr;
                        end
                        r_hits     <= n_hits;
                        r_misses   <= n_misses;
                        r_out_hit  <= r_found;
                        r_out_data <= {{OUT_PAD{1'b0}}, n_misses, n_hits,
                                       SLOT_OUT_W'(n_slot)};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_hit;

endmodule

[rtl/core/fpr_checker.sv]
module fpr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      o_s_axis_tready,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [fpr_pkg::OUT_W-1:0] o_m_axis_tdata,
    input logic                      o_m_axis_tuser
);
    import fpr_pkg::*;

`include "fifo_page_replacement_unit_assert.svh"

    `FPR_ASSERT(a_hit_counted, (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[37:6] != '0))
    `FPR_ASSERT(a_miss_counted, (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[69:38] != '0))
    `FPR_ASSERT_NEXT(a_busy_after_accept, (i_s_axis_tvalid && o_s_axis_tready), !o_s_axis_tready)
    `FPR_ASSERT_NEXT(a_hold_valid, (o_m_axis_tvalid && !i_m_axis_tready), o_m_axis_tvalid)
    `FPR_ASSERT_NEXT(a_hold_stalled, (o_m_axis_tvalid && !i_m_axis_tready), $stable(o_m_axis_tdata))

endmodule

bind fifo_page_replacement_unit fpr_checker u_fpr_checker (.*);
